/* hdl/rcu_pkg.sv */
// Shared types, codes and helpers for the routing wire cost estimator.
// Depends on nothing; imported by rcu_wire_table, rcu_cost_pipe and the top level.
package rcu_pkg;

	localparam int NUM_WIRE_TYPES_DEF = 16;
	localparam int GRID_SIZE_DEF      = 1024;

	// segment counts before the grid clamp stay below 2^12
	localparam int SEG_W = 12;

	localparam logic [27:0] ROUND_TOL = 28'd66;
	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [47:0] COST_CAP  = 48'hFFFF_FFFF_FFFF;

	localparam logic REQ_QUERY = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef enum logic [1:0] {
		CFG_MODE     = 2'd0,
		CFG_PIN_LIN  = 2'd1,
		CFG_SINK     = 2'd2,
		CFG_PIN_BASE = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FLD_BASE  = 3'd0,
		FLD_LIN   = 3'd1,
		FLD_QUAD  = 3'd2,
		FLD_CAP   = 3'd3,
		FLD_INV   = 3'd4,
		FLD_ORTHO = 3'd5
	} field_t;

	typedef enum logic [1:0] {
		KIND_HCHAN = 2'd0,
		KIND_VCHAN = 2'd1,
		KIND_IPIN  = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_SINK = 2'd1,
		CLS_CALC = 2'd2
	} cls_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] lin;
		logic [31:0] quad;
		logic [31:0] cap;
		logic [16:0] inv;
	} wire_entry_t;

	typedef struct packed {
		logic [SEG_W-1:0] s;
		logic [SEG_W-1:0] o;
		logic [31:0]      base_s;
		logic [31:0]      base_o;
		logic [31:0]      lin_s;
		logic [31:0]      lin_o;
		logic [31:0]      quad_s;
		logic [31:0]      quad_o;
		logic [31:0]      cap_s;
		logic [31:0]      cap_o;
		logic [31:0]      rup;
		logic [16:0]      crit;
	} cost_in_t;

	function automatic logic [47:0] sat48(input logic [63:0] v);
		return (v > 64'(COST_CAP)) ? COST_CAP : v[47:0];
	endfunction

	// ceil(p / 2^16 - tolerance), clamped to seg_max
	function automatic logic [SEG_W-1:0] seg_count(input logic [27:0] p,
			input logic [16:0] seg_max);
		logic [28:0] q;
		q = 29'(p) - 29'(ROUND_TOL) + 29'h0FFFF;
		if (p <= ROUND_TOL)
			return '0;
		if (17'(q[28:16]) > seg_max)
			return seg_max[SEG_W-1:0];
		return q[27:16];
	endfunction

endpackage

/* hdl/rcu_ram.sv */
// Generic single write, single read RAM with registered read-first output.
// Depends on nothing.
module rcu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
		if (we)
			mem_q[waddr] <= wdata;
	end

endmodule

/* hdl/rcu_wire_table.sv */
// Per-wire-type table: one RAM per field for the node's own type, one more
// set for the orthogonal type. Depends on rcu_pkg and rcu_ram.
module rcu_wire_table import rcu_pkg::*; #(
	parameter int NUM_WIRE_TYPES = NUM_WIRE_TYPES_DEF
) (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [2:0]  field,
	input  logic [31:0] value,
	input  logic [3:0]  wire_type,
	input  logic        rd_en_a,
	input  logic        rd_en_b,
	output wire_entry_t ent_a,
	output wire_entry_t ent_b
);

	localparam int IW = $clog2(NUM_WIRE_TYPES);

	function automatic logic [IW-1:0] wrap_idx(input logic [3:0] v);
		logic [IW-1:0] r;
		r = '0;
		for (int i = 0; i < 16; i++)
			if (v == 4'(i))
				r = IW'(i % NUM_WIRE_TYPES);
		return r;
	endfunction

	logic [IW-1:0] idx;
	logic [IW-1:0] oidx;
	logic [3:0]    ortho_rd;
	logic [5:0]    we_f;

	assign idx  = wrap_idx(wire_type);
	assign oidx = wrap_idx(ortho_rd);

	always_comb begin
		we_f = '0;
		if (wr_en) begin
			case (field)
				FLD_BASE:  we_f[0] = 1'b1;
				FLD_LIN:   we_f[1] = 1'b1;
				FLD_QUAD:  we_f[2] = 1'b1;
				FLD_CAP:   we_f[3] = 1'b1;
				FLD_INV:   we_f[4] = 1'b1;
				FLD_ORTHO: we_f[5] = 1'b1;
				default:   we_f = '0;
			endcase
		end
	end

	rcu_ram #(.WIDTH(32), .DEPTH(NUM_WIRE_TYPES)) u_base_a (.clk, .we(we_f[0]), .waddr(idx),
		.wdata(value), .re(rd_en_a), .raddr(idx), .rdata(ent_a.base));
	rcu_ram #(.WIDTH(32), .DEPTH(NUM_WIRE_TYPES)) u_lin_a (.clk, .we(we_f[1]), .waddr(idx),
		.wdata(value), .re(rd_en_a), .raddr(idx), .rdata(ent_a.lin));
	rcu_ram #(.WIDTH(32), .DEPTH(NUM_WIRE_TYPES)) u_quad_a (.clk, .we(we_f[2]), .waddr(idx),
		.wdata(value), .re(rd_en_a), .raddr(idx), .rdata(ent_a.quad));
	rcu_ram #(.WIDTH(32), .DEPTH(NUM_WIRE_TYPES)) u_cap_a (.clk, .we(we_f[3]), .waddr(idx),
		.wdata(value), .re(rd_en_a), .raddr(idx), .rdata(ent_a.cap));
	rcu_ram #(.WIDTH(17), .DEPTH(NUM_WIRE_TYPES)) u_inv_a (.clk, .we(we_f[4]), .waddr(idx),
		.wdata(value[16:0]), .re(rd_en_a), .raddr(idx), .rdata(ent_a.inv));
	rcu_ram #(.WIDTH(4), .DEPTH(NUM_WIRE_TYPES)) u_ortho_a (.clk, .we(we_f[5]), .waddr(idx),
		.wdata(value[3:0]), .re(rd_en_a), .raddr(idx), .rdata(ortho_rd));

	// orthogonal copy: read one stage later at the type just fetched
	rcu_ram #(.WIDTH(32), .DEPTH(NUM_WIRE_TYPES)) u_base_b (.clk, .we(we_f[0]), .waddr(idx),
		.wdata(value), .re(rd_en_b), .raddr(oidx), .rdata(ent_b.base));
	rcu_ram #(.WIDTH(32), .DEPTH(NUM_WIRE_TYPES)) u_lin_b (.clk, .we(we_f[1]), .waddr(idx),
		.wdata(value), .re(rd_en_b), .raddr(oidx), .rdata(ent_b.lin));
	rcu_ram #(.WIDTH(32), .DEPTH(NUM_WIRE_TYPES)) u_quad_b (.clk, .we(we_f[2]), .waddr(idx),
		.wdata(value), .re(rd_en_b), .raddr(oidx), .rdata(ent_b.quad));
	rcu_ram #(.WIDTH(32), .DEPTH(NUM_WIRE_TYPES)) u_cap_b (.clk, .we(we_f[3]), .waddr(idx),
		.wdata(value), .re(rd_en_b), .raddr(oidx), .rdata(ent_b.cap));
	rcu_ram #(.WIDTH(17), .DEPTH(NUM_WIRE_TYPES)) u_inv_b (.clk, .we(we_f[4]), .waddr(idx),
		.wdata(value[16:0]), .re(rd_en_b), .raddr(oidx), .rdata(ent_b.inv));

endmodule

/* hdl/rcu_cost_pipe.sv */
// Cost arithmetic stages four to ten: products, saturating sums, the
// upstream RC term and the criticality blend. Depends on rcu_pkg.
module rcu_cost_pipe import rcu_pkg::*; (
	input  logic        clk,
	input  logic [6:0]  en,
	input  cost_in_t    cin,
	input  logic [31:0] pin_lin,
	input  logic [31:0] pin_base,
	input  logic [31:0] sink,
	output logic [47:0] cost
);

	cost_in_t    in_s4;

	logic [43:0] bs_s5, bo_s5, ls_s5, lo_s5, cs_s5, co_s5;
	logic [23:0] ss_s5, oo_s5;
	logic [31:0] quad_s_s5, quad_o_s5, rup_s5;
	logic [16:0] crit_s5;

	logic [47:0] cong_s6, tdel1_s6;
	logic [44:0] load_s6;
	logic [55:0] sqs_s6, sqo_s6;
	logic [31:0] rup_s6;
	logic [16:0] crit_s6;

	logic [47:0] cong_s7, tdel2_s7;
	logic [44:0] rhi_s7;
	logic [63:0] rlo_s7;
	logic [16:0] crit_s7;

	logic [47:0] cong_s8, tdel2_s8, vsat_s8;
	logic [16:0] crit_s8;

	logic [47:0] cong_s9, tdel_s9;
	logic [16:0] crit_s9;

	logic [48:0] ctl_s10, ncl_s10;
	logic [32:0] cth_s10, nch_s10;

	logic [47:0] t_a, t_b;
	logic [16:0] ncrit;
	logic [65:0] sum;

	assign t_a   = sat48(64'(tdel1_s6) + 64'(sqs_s6));
	assign t_b   = sat48(64'(tdel2_s8) + 64'(vsat_s8));
	assign ncrit = ONE_Q16 - crit_s9;

	always_ff @(posedge clk) begin
		if (en[0])
			in_s4 <= cin;
		if (en[1]) begin
			bs_s5     <= 44'(in_s4.s) * 44'(in_s4.base_s);
			bo_s5     <= 44'(in_s4.o) * 44'(in_s4.base_o);
			ls_s5     <= 44'(in_s4.s) * 44'(in_s4.lin_s);
			lo_s5     <= 44'(in_s4.o) * 44'(in_s4.lin_o);
			cs_s5     <= 44'(in_s4.s) * 44'(in_s4.cap_s);
			co_s5     <= 44'(in_s4.o) * 44'(in_s4.cap_o);
			ss_s5     <= 24'(in_s4.s) * 24'(in_s4.s);
			oo_s5     <= 24'(in_s4.o) * 24'(in_s4.o);
			quad_s_s5 <= in_s4.quad_s;
			quad_o_s5 <= in_s4.quad_o;
			rup_s5    <= in_s4.rup;
			crit_s5   <= in_s4.crit;
		end
		if (en[2]) begin
			cong_s6  <= sat48(64'(bs_s5) + 64'(bo_s5) + 64'(pin_base) + 64'(sink));
			tdel1_s6 <= sat48(64'(ls_s5) + 64'(lo_s5));
			load_s6  <= 45'(cs_s5) + 45'(co_s5);
			sqs_s6   <= 56'(ss_s5) * 56'(quad_s_s5);
			sqo_s6   <= 56'(oo_s5) * 56'(quad_o_s5);
			rup_s6   <= rup_s5;
			crit_s6  <= crit_s5;
		end
		if (en[3]) begin
			cong_s7  <= cong_s6;
			tdel2_s7 <= sat48(64'(t_a) + 64'(sqo_s6));
			rhi_s7   <= 45'(rup_s6) * 45'(load_s6[44:32]);
			rlo_s7   <= 64'(rup_s6) * 64'(load_s6[31:0]);
			crit_s7  <= crit_s6;
		end
		if (en[4]) begin
			cong_s8  <= cong_s7;
			tdel2_s8 <= tdel2_s7;
			vsat_s8  <= sat48((64'(rhi_s7) << 16) + (rlo_s7 >> 16));
			crit_s8  <= crit_s7;
		end
		if (en[5]) begin
			cong_s9 <= cong_s8;
			tdel_s9 <= sat48(64'(t_b) + 64'(pin_lin));
			crit_s9 <= crit_s8;
		end
		if (en[6]) begin
			// split the 48-bit operands so each product stays narrow
			ctl_s10 <= 49'(crit_s9) * 49'(tdel_s9[31:0]);
			cth_s10 <= 33'(crit_s9) * 33'(tdel_s9[47:32]);
			ncl_s10 <= 49'(ncrit) * 49'(cong_s9[31:0]);
			nch_s10 <= 33'(ncrit) * 33'(cong_s9[47:32]);
		end
	end

	assign sum = (66'(cth_s10) << 32) + 66'(ctl_s10) + (66'(nch_s10) << 32)
		+ 66'(ncl_s10) + 66'(32768);
	assign cost = sum[63:16];

endmodule

/* hdl/routing_wire_cost_estimator_unit.sv */
// Top level of the routing wire cost estimator: handshake, configuration,
// geometry and segment stages. Depends on rcu_pkg, rcu_wire_table, rcu_cost_pipe.
//
// Use: one item per beat on the request channel (req_valid / req_stall).
// A table write item stores one field of one wire type and answers zero;
// a query answers the lookahead cost and the two segment counts. Every
// item gives exactly one beat on rsp_valid / rsp_stall, in order.
// Configuration registers are written on cfg_valid / cfg_ready (always
// ready) and must only change while the pipeline is empty.
// An accepted item passes eleven registered stages to rsp_valid; throughput is
// one item per cycle while rsp_stall is low. The longest stages are the
// 32-bit products and the 48-bit saturating adds.
// A table entry written by one item is seen by any later query, even the
// very next beat. Table contents are undefined until written.
// Reset clears the valid bits and configuration registers; the table is
// not cleared. While rsp_stall holds, the result beat is kept and earlier
// stages keep filling bubbles, so req_stall rises only when every stage
// is occupied.
module routing_wire_cost_estimator_unit import rcu_pkg::*; #(
	parameter int NUM_WIRE_TYPES = NUM_WIRE_TYPES_DEF,
	parameter int GRID_SIZE      = GRID_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [3:0]  wire_type,
	input  logic [2:0]  table_field,
	input  logic [31:0] table_value,
	input  logic [1:0]  node_kind,
	input  logic [9:0]  node_x0,
	input  logic [9:0]  node_y0,
	input  logic [9:0]  node_far_end,
	input  logic [9:0]  dest_x,
	input  logic [9:0]  dest_y,
	input  logic [16:0] criticality,
	input  logic [31:0] up_res,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [47:0] cost_est,
	output logic [9:0]  same_dir_segments,
	output logic [9:0]  ortho_dir_segments,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NST = 11;
	localparam logic [16:0] SEG_MAX = 17'(GRID_SIZE - 1);

	logic          valid_q [1:NST];
	logic [NST+1:1] rdy;
	logic          accept;

	logic        mode_q;
	logic [31:0] pin_lin_q, sink_q, pin_base_q;

	// stage 1: captured request
	logic        req_type_s1;
	logic [1:0]  kind_s1;
	logic [9:0]  xlow_s1, ylow_s1, far_s1, tx_s1, ty_s1;
	logic [16:0] crit_s1;
	logic [31:0] rup_s1;

	// stage 2: distances
	cls_t        cls_s2;
	logic [10:0] d_same_s2, d_orth_s2;
	wire_entry_t ent_a_s2;
	logic [16:0] crit_s2;
	logic [31:0] rup_s2;

	// stage 3: scaled distances
	cls_t        cls_s3;
	logic [27:0] p_same_s3, p_orth_s3;
	wire_entry_t ent_a_s3, ent_b_s3;
	logic [16:0] crit_s3;
	logic [31:0] rup_s3;

	cls_t             cls_q  [4:10];
	logic [SEG_W-1:0] sseg_q [4:10];
	logic [SEG_W-1:0] oseg_q [4:10];

	logic [47:0] cost_q;
	logic [9:0]  same_q, orth_q;

	wire_entry_t ent_a, ent_b;
	cost_in_t    cin;
	logic [47:0] cost;

	logic [9:0]  across, t_across, low_along, t_along;
	logic        pass;
	logic [10:0] d_same, d_orth;
	cls_t        cls_c;
	logic [16:0] crit_c;

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && rdy[1];
	assign req_stall = !rdy[1];
	assign rsp_valid = valid_q[NST];

	always_comb begin
		rdy[NST+1] = !rsp_stall;
		for (int k = NST; k >= 1; k--)
			rdy[k] = !valid_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++)
				valid_q[k] <= 1'b0;
		end else begin
			if (rdy[1])
				valid_q[1] <= req_valid;
			for (int k = 2; k <= NST; k++)
				if (rdy[k])
					valid_q[k] <= valid_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			pin_lin_q  <= '0;
			sink_q     <= '0;
			pin_base_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:     mode_q     <= cfg_data[0];
				CFG_PIN_LIN:  pin_lin_q  <= cfg_data;
				CFG_SINK:     sink_q     <= cfg_data;
				CFG_PIN_BASE: pin_base_q <= cfg_data;
				default:      mode_q     <= mode_q;
			endcase
		end
	end

	rcu_wire_table #(.NUM_WIRE_TYPES(NUM_WIRE_TYPES)) u_table (
		.clk,
		.wr_en     (accept && (req_type == REQ_WRITE)),
		.field     (table_field),
		.value     (table_value),
		.wire_type,
		.rd_en_a   (rdy[1]),
		.rd_en_b   (rdy[2]),
		.ent_a,
		.ent_b
	);

	// geometry of the stage 1 node against the target
	always_comb begin
		if (kind_s1 == KIND_HCHAN) begin
			across = ylow_s1; t_across = ty_s1; low_along = xlow_s1; t_along = tx_s1;
		end else begin
			across = xlow_s1; t_across = tx_s1; low_along = ylow_s1; t_along = ty_s1;
		end
		if (across > t_across) begin
			d_orth = 11'(across) - 11'(t_across) + 11'd1;
			pass   = 1'b1;
		end else if (11'(across) + 11'd1 < 11'(t_across)) begin
			d_orth = 11'(t_across) - 11'(across);
			pass   = 1'b1;
		end else begin
			d_orth = '0;
			pass   = 1'b0;
		end
		if (11'(low_along) > 11'(t_along) + 11'(pass))
			d_same = 11'(low_along) - 11'(pass) - 11'(t_along);
		else if (11'(far_s1) + 11'(pass) < 11'(t_along))
			d_same = 11'(t_along) - 11'(pass) - 11'(far_s1);
		else
			d_same = '0;

		if (req_type_s1 == REQ_WRITE || mode_q || kind_s1 == KIND_OTHER)
			cls_c = CLS_ZERO;
		else if (kind_s1 == KIND_IPIN)
			cls_c = CLS_SINK;
		else
			cls_c = CLS_CALC;

		crit_c = (crit_s1 > ONE_Q16) ? ONE_Q16 : crit_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			req_type_s1 <= req_type;
			kind_s1     <= node_kind;
			xlow_s1     <= node_x0;
			ylow_s1     <= node_y0;
			far_s1      <= node_far_end;
			tx_s1       <= dest_x;
			ty_s1       <= dest_y;
			crit_s1     <= criticality;
			rup_s1      <= up_res;
		end
		if (rdy[2]) begin
			cls_s2    <= cls_c;
			d_same_s2 <= d_same;
			d_orth_s2 <= d_orth;
			ent_a_s2  <= ent_a;
			crit_s2   <= crit_c;
			rup_s2    <= rup_s1;
		end
		if (rdy[3]) begin
			cls_s3    <= cls_s2;
			p_same_s3 <= 28'(d_same_s2) * 28'(ent_a_s2.inv);
			p_orth_s3 <= 28'(d_orth_s2) * 28'(ent_b.inv);
			ent_a_s3  <= ent_a_s2;
			ent_b_s3  <= ent_b;
			crit_s3   <= crit_s2;
			rup_s3    <= rup_s2;
		end
	end

	always_comb begin
		cin.s      = seg_count(p_same_s3, SEG_MAX);
		cin.o      = seg_count(p_orth_s3, SEG_MAX);
		cin.base_s = ent_a_s3.base;
		cin.base_o = ent_b_s3.base;
		cin.lin_s  = ent_a_s3.lin;
		cin.lin_o  = ent_b_s3.lin;
		cin.quad_s = ent_a_s3.quad;
		cin.quad_o = ent_b_s3.quad;
		cin.cap_s  = ent_a_s3.cap;
		cin.cap_o  = ent_b_s3.cap;
		cin.rup    = rup_s3;
		cin.crit   = crit_s3;
	end

	rcu_cost_pipe u_cost (
		.clk,
		.en       (rdy[10:4]),
		.cin,
		.pin_lin  (pin_lin_q),
		.pin_base (pin_base_q),
		.sink     (sink_q),
		.cost
	);

	// carry class and counts alongside the cost stages
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			cls_q[4]  <= cls_s3;
			sseg_q[4] <= cin.s;
			oseg_q[4] <= cin.o;
		end
		for (int k = 5; k <= 10; k++) begin
			if (rdy[k]) begin
				cls_q[k]  <= cls_q[k-1];
				sseg_q[k] <= sseg_q[k-1];
				oseg_q[k] <= oseg_q[k-1];
			end
		end
		if (rdy[NST]) begin
			case (cls_q[10])
				CLS_SINK: begin
					cost_q <= 48'(sink_q);
					same_q <= '0;
					orth_q <= '0;
				end
				CLS_CALC: begin
					cost_q <= cost;
					same_q <= sseg_q[10][9:0];
					orth_q <= oseg_q[10][9:0];
				end
				default: begin
					cost_q <= '0;
					same_q <= '0;
					orth_q <= '0;
				end
			endcase
		end
	end

	assign cost_est           = cost_q;
	assign same_dir_segments  = same_q;
	assign ortho_dir_segments = orth_q;

endmodule

/* hdl/rcu_checker.sv */
// Port-level checks for the routing wire cost estimator, bound to the top.
// Depends on routing_wire_cost_estimator_unit.
module rcu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [47:0] cost_est,
	input logic [9:0]  same_dir_segments,
	input logic [9:0]  ortho_dir_segments,
	input logic        cfg_ready
);

	// a held result beat keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(cost_est)
			&& $stable(same_dir_segments) && $stable(ortho_dir_segments))
		else $error("result beat changed while stalled");

	// with the output empty no stage can be blocked
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with empty output");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !rsp_valid)
		else $error("result beat straight after reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind routing_wire_cost_estimator_unit rcu_checker u_rcu_checker (
	.clk,
	.arst_n,
	.req_stall,
	.rsp_valid,
	.rsp_stall,
	.cost_est,
	.same_dir_segments,
	.ortho_dir_segments,
	.cfg_ready
);
